// File: rtl/assert_macros.svh
// Assertion helpers, included by the rasterizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clr_pkg.sv
package clr_pkg;

    localparam int CLR_COORD_BITS = 12;

    localparam int AREA_POS_BITS  = 10;
    localparam int AREA_SIZE_BITS = 11;
    localparam int ABS_BITS       = 11;
    localparam int COLOR_BITS     = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_TOP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_HEIGHT = 2'd3;

    localparam logic [AREA_SIZE_BITS-1:0] AREA_WIDTH_RST  = 11'd320;
    localparam logic [AREA_SIZE_BITS-1:0] AREA_HEIGHT_RST = 11'd240;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic y_major;
        logic y_down;
        logic x_down;
    } t_dir_flags;

    // Signed width of the walk position: holds endpoint differences and clamped coords.
    function automatic int cur_bits(int cb);
        return ((cb > ABS_BITS) ? cb : ABS_BITS) + 1;
    endfunction

endpackage

// File: rtl/clr_cmd_if.sv
interface clr_cmd_if import clr_pkg::*; #(
    parameter int COORD_BITS = CLR_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] begin_x;
    logic signed [COORD_BITS-1:0] begin_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        line_color;

    modport source (
        output valid, kind, begin_x, begin_y, end_x, end_y, line_color,
        input  ready
    );
    modport sink (
        input  valid, kind, begin_x, begin_y, end_x, end_y, line_color,
        output ready
    );
endinterface

// File: rtl/clr_pix_if.sv
interface clr_pix_if import clr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ABS_BITS-1:0]   pixel_x;
    logic [ABS_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  visible;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
        output ready
    );
endinterface

// File: rtl/clr_setup.sv
module clr_setup import clr_pkg::*; #(
    parameter int COORD_BITS = CLR_COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0]               i_begin_x,
    input  logic signed [COORD_BITS-1:0]               i_begin_y,
    input  logic signed [COORD_BITS-1:0]               i_end_x,
    input  logic signed [COORD_BITS-1:0]               i_end_y,
    input  logic [AREA_SIZE_BITS-1:0]                  i_area_width,
    input  logic [AREA_SIZE_BITS-1:0]                  i_area_height,
    output logic                                       o_active,
    output logic signed [cur_bits(COORD_BITS)-1:0]     o_cur_x,
    output logic signed [cur_bits(COORD_BITS)-1:0]     o_cur_y,
    output logic [cur_bits(COORD_BITS)-2:0]            o_delta_major,
    output logic [cur_bits(COORD_BITS)-2:0]            o_delta_minor,
    output logic signed [cur_bits(COORD_BITS)+1:0]     o_err,
    output t_dir_flags                                 o_dir
);
    localparam int CW = cur_bits(COORD_BITS);
    localparam int DW = CW - 1;

    logic signed [CW-1:0] bx, by, ex, ey;
    logic signed [CW-1:0] adx_full, ady_full;
    logic [DW-1:0]        adx, ady;
    logic signed [CW-1:0] w_max, h_max;
    logic signed [CW-1:0] lo, hi, lo_c, hi_c;
    logic                 axis, empty;

    function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] top);
        logic signed [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > top) begin
            r = top;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign bx = CW'(i_begin_x);
    assign by = CW'(i_begin_y);
    assign ex = CW'(i_end_x);
    assign ey = CW'(i_end_y);

    assign adx_full = (ex > bx) ? (ex - bx) : (bx - ex);
    assign ady_full = (ey > by) ? (ey - by) : (by - ey);
    assign adx = adx_full[DW-1:0];
    assign ady = ady_full[DW-1:0];

    assign w_max = $signed({{(CW-AREA_SIZE_BITS){1'b0}}, i_area_width}) - CW'(1);
    assign h_max = $signed({{(CW-AREA_SIZE_BITS){1'b0}}, i_area_height}) - CW'(1);

    assign axis  = (adx != '0) != (ady != '0);
    assign empty = (i_area_width == '0) || (i_area_height == '0);

    // Axis lines run from the lower to the higher clamped coordinate.
    always_comb begin
        if (ady == '0) begin
            lo = (bx < ex) ? bx : ex;
            hi = (bx < ex) ? ex : bx;
            lo_c = clamp(lo, w_max);
            hi_c = clamp(hi, w_max);
        end else begin
            lo = (by < ey) ? by : ey;
            hi = (by < ey) ? ey : by;
            lo_c = clamp(lo, h_max);
            hi_c = clamp(hi, h_max);
        end
    end

    always_comb begin
        o_active = !(axis && empty);
        if (axis) begin
            o_delta_minor = '0;
            o_delta_major = DW'(hi_c - lo_c);
            if (ady == '0) begin
                o_cur_x = lo_c;
                o_cur_y = clamp(by, h_max);
                o_dir   = '{y_major: 1'b0, y_down: 1'b0, x_down: 1'b0};
            end else begin
                o_cur_x = clamp(bx, w_max);
                o_cur_y = lo_c;
                o_dir   = '{y_major: 1'b1, y_down: 1'b0, x_down: 1'b0};
            end
        end else begin
            o_cur_x      = bx;
            o_cur_y      = by;
            o_dir.x_down = !(ex > bx);
            o_dir.y_down = !(ey > by);
            if (adx >= ady) begin
                o_dir.y_major = 1'b0;
                o_delta_major = adx;
                o_delta_minor = ady;
            end else begin
                o_dir.y_major = 1'b1;
                o_delta_major = ady;
                o_delta_minor = adx;
            end
        end
        o_err = -$signed({3'b000, o_delta_major});
    end

endmodule

// File: rtl/clr_walk.sv
module clr_walk import clr_pkg::*; #(
    parameter int COORD_BITS = CLR_COORD_BITS
) (
    input  logic signed [cur_bits(COORD_BITS)-1:0]     i_cur_x,
    input  logic signed [cur_bits(COORD_BITS)-1:0]     i_cur_y,
    input  logic signed [cur_bits(COORD_BITS)+1:0]     i_err,
    input  logic [cur_bits(COORD_BITS)-2:0]            i_delta_major,
    input  logic [cur_bits(COORD_BITS)-2:0]            i_delta_minor,
    input  logic [cur_bits(COORD_BITS)-2:0]            i_steps_left,
    input  t_dir_flags                                 i_dir,
    input  logic [AREA_POS_BITS-1:0]                   i_area_left,
    input  logic [AREA_POS_BITS-1:0]                   i_area_top,
    input  logic [AREA_SIZE_BITS-1:0]                  i_area_width,
    input  logic [AREA_SIZE_BITS-1:0]                  i_area_height,
    output logic [ABS_BITS-1:0]                        o_pixel_x,
    output logic [ABS_BITS-1:0]                        o_pixel_y,
    output logic                                       o_visible,
    output logic                                       o_last,
    output logic signed [cur_bits(COORD_BITS)-1:0]     o_cur_x,
    output logic signed [cur_bits(COORD_BITS)-1:0]     o_cur_y,
    output logic signed [cur_bits(COORD_BITS)+1:0]     o_err,
    output logic [cur_bits(COORD_BITS)-2:0]            o_steps_left
);
    localparam int CW = cur_bits(COORD_BITS);
    localparam int DW = CW - 1;
    localparam int EW = DW + 3;

    logic signed [CW-1:0] w_ext, h_ext;
    logic signed [EW-1:0] err_add, err_sub;
    logic                 minor_take, step_x, step_y;

    assign w_ext = $signed({{(CW-AREA_SIZE_BITS){1'b0}}, i_area_width});
    assign h_ext = $signed({{(CW-AREA_SIZE_BITS){1'b0}}, i_area_height});

    assign o_visible = !i_cur_x[CW-1] && (i_cur_x < w_ext) &&
                       !i_cur_y[CW-1] && (i_cur_y < h_ext);
    assign o_last    = (i_steps_left == '0);

    // Absolute position wraps modulo 2048.
    assign o_pixel_x = i_cur_x[ABS_BITS-1:0] + {1'b0, i_area_left};
    assign o_pixel_y = i_cur_y[ABS_BITS-1:0] + {1'b0, i_area_top};

    assign err_add    = i_err + $signed({2'b00, i_delta_minor, 1'b0});
    assign err_sub    = err_add - $signed({2'b00, i_delta_major, 1'b0});
    assign minor_take = !err_add[EW-1];

    assign step_x = !i_dir.y_major || minor_take;
    assign step_y =  i_dir.y_major || minor_take;

    always_comb begin
        o_cur_x = i_cur_x;
        o_cur_y = i_cur_y;
        if (step_x) begin
            o_cur_x = i_dir.x_down ? (i_cur_x - CW'(1)) : (i_cur_x + CW'(1));
        end
        if (step_y) begin
            o_cur_y = i_dir.y_down ? (i_cur_y - CW'(1)) : (i_cur_y + CW'(1));
        end
    end

    assign o_err        = minor_take ? err_sub : err_add;
    assign o_steps_left = i_steps_left - DW'(1);

endmodule

// File: rtl/clipped_line_rasterizer_core.sv
// Channel  Dir  Carries
// i_cmd    in   kind, begin_x, begin_y, end_x, end_y, line_color
// o_pix    out  pixel_x, pixel_y, pixel_color, visible, last_pixel
// i_cfg_*  in   area_left, area_top, area_width, area_height writes
//
// One request per cycle sustained while o_pix is not stalled; each request is held in
// the input register, then setup loads a start into the walk state, or the walk logic
// puts a step's pixel into the output register and advances the walk state registers.
// Start requests produce no pixel. Reset (synchronous, active low) drops the line and
// both valid flags and reloads the area registers; no clearing pass.
// A stalled o_pix holds the output register and backs up through the input register.
`include "assert_macros.svh"

module clipped_line_rasterizer_core import clr_pkg::*; #(
    parameter int COORD_BITS = CLR_COORD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    clr_cmd_if.sink                  i_cmd,
    clr_pix_if.source                o_pix,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int CW = cur_bits(COORD_BITS);
    localparam int DW = CW - 1;
    localparam int EW = DW + 3;

    // area registers
    logic [AREA_POS_BITS-1:0]  r_area_left, r_area_top;
    logic [AREA_SIZE_BITS-1:0] r_area_width, r_area_height;

    // input register
    logic                         r_in_valid;
    logic                         r_in_kind;
    logic signed [COORD_BITS-1:0] r_in_bx, r_in_by, r_in_ex, r_in_ey;
    logic [COLOR_BITS-1:0]        r_in_color;

    // line state
    logic                  r_active;
    logic signed [CW-1:0]  r_cur_x, r_cur_y;
    logic signed [EW-1:0]  r_err;
    logic [DW-1:0]         r_delta_major, r_delta_minor, r_steps_left;
    t_dir_flags            r_dir;
    logic [COLOR_BITS-1:0] r_held_color;

    // output register
    logic                  r_out_valid;
    logic [ABS_BITS-1:0]   r_out_x, r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_visible, r_out_last;

    logic                 n_out_valid;
    logic                 process, proc_start, proc_step;

    logic                 setup_active;
    logic signed [CW-1:0] setup_cur_x, setup_cur_y;
    logic [DW-1:0]        setup_major, setup_minor;
    logic signed [EW-1:0] setup_err;
    t_dir_flags           setup_dir;

    logic [ABS_BITS-1:0]  walk_px, walk_py;
    logic                 walk_visible, walk_last;
    logic signed [CW-1:0] walk_cur_x, walk_cur_y;
    logic signed [EW-1:0] walk_err;
    logic [DW-1:0]        walk_steps;

    assign process    = r_in_valid && (!r_out_valid || o_pix.ready);
    assign proc_start = process && (r_in_kind == KIND_START);
    assign proc_step  = process && (r_in_kind == KIND_STEP) && r_active;

    assign i_cmd.ready = !r_in_valid || process;

    assign n_out_valid = proc_step || (r_out_valid && !o_pix.ready);

    clr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_begin_x     (r_in_bx),
        .i_begin_y     (r_in_by),
        .i_end_x       (r_in_ex),
        .i_end_y       (r_in_ey),
        .i_area_width  (r_area_width),
        .i_area_height (r_area_height),
        .o_active      (setup_active),
        .o_cur_x       (setup_cur_x),
        .o_cur_y       (setup_cur_y),
        .o_delta_major (setup_major),
        .o_delta_minor (setup_minor),
        .o_err         (setup_err),
        .o_dir         (setup_dir)
    );

    clr_walk #(.COORD_BITS(COORD_BITS)) u_walk (
        .i_cur_x       (r_cur_x),
        .i_cur_y       (r_cur_y),
        .i_err         (r_err),
        .i_delta_major (r_delta_major),
        .i_delta_minor (r_delta_minor),
        .i_steps_left  (r_steps_left),
        .i_dir         (r_dir),
        .i_area_left   (r_area_left),
        .i_area_top    (r_area_top),
        .i_area_width  (r_area_width),
        .i_area_height (r_area_height),
        .o_pixel_x     (walk_px),
        .o_pixel_y     (walk_py),
        .o_visible     (walk_visible),
        .o_last        (walk_last),
        .o_cur_x       (walk_cur_x),
        .o_cur_y       (walk_cur_y),
        .o_err         (walk_err),
        .o_steps_left  (walk_steps)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_active      <= 1'b0;
            r_area_left   <= '0;
            r_area_top    <= '0;
            r_area_width  <= AREA_WIDTH_RST;
            r_area_height <= AREA_HEIGHT_RST;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            r_out_valid <= n_out_valid;
            if (proc_start) begin
                r_active <= setup_active;
            end else if (proc_step && walk_last) begin
                r_active <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AREA_LEFT:   r_area_left   <= i_cfg_data[AREA_POS_BITS-1:0];
                    CFG_AREA_TOP:    r_area_top    <= i_cfg_data[AREA_POS_BITS-1:0];
                    CFG_AREA_WIDTH:  r_area_width  <= i_cfg_data[AREA_SIZE_BITS-1:0];
                    CFG_AREA_HEIGHT: r_area_height <= i_cfg_data[AREA_SIZE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_kind  <= i_cmd.kind;
            r_in_bx    <= i_cmd.begin_x;
            r_in_by    <= i_cmd.begin_y;
            r_in_ex    <= i_cmd.end_x;
            r_in_ey    <= i_cmd.end_y;
            r_in_color <= i_cmd.line_color;
        end
        if (proc_start) begin
            r_cur_x       <= setup_cur_x;
            r_cur_y       <= setup_cur_y;
            r_err         <= setup_err;
            r_delta_major <= setup_major;
            r_delta_minor <= setup_minor;
            r_steps_left  <= setup_major;
            r_dir         <= setup_dir;
            r_held_color  <= r_in_color;
        end else if (proc_step && !walk_last) begin
            r_cur_x      <= walk_cur_x;
            r_cur_y      <= walk_cur_y;
            r_err        <= walk_err;
            r_steps_left <= walk_steps;
        end
        if (proc_step) begin
            r_out_x       <= walk_px;
            r_out_y       <= walk_py;
            r_out_color   <= r_held_color;
            r_out_visible <= walk_visible;
            r_out_last    <= walk_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.pixel_color = r_out_color;
    assign o_pix.visible     = r_out_visible;
    assign o_pix.last_pixel  = r_out_last;

    `ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n,
        proc_step && walk_last, !r_active, "line still active after its last pixel")
    `ASSERT_NEXT(a_empty_axis_idle, i_clk, i_rst_n,
        proc_start && !setup_active, !r_active, "axis line on empty area became active")
    `ASSERT_NEXT(a_steps_count_down, i_clk, i_rst_n,
        proc_step && !walk_last, r_steps_left == $past(r_steps_left) - DW'(1),
        "step count did not advance by one")
    `ASSERT_NEXT(a_in_reg_held, i_clk, i_rst_n,
        r_in_valid && !process, r_in_valid && $stable(r_in_kind),
        "pending request lost while output stalled")

endmodule
